// File: rtl/gbn_pkg.sv
// ----------------------------------------------------------------------------
// gbn_pkg: shared constants and codes for the Go-Back-N sender window
// Action and kind codes, register reset values, timer constants and widths.
// ----------------------------------------------------------------------------
package gbn_pkg;

  // input item kinds
  localparam logic [1:0] KIND_NEW   = 2'd0;
  localparam logic [1:0] KIND_ACK   = 2'd1;
  localparam logic [1:0] KIND_TIMER = 2'd2;
  localparam logic [1:0] KIND_NONE  = 2'd3;

  // result actions
  localparam logic [2:0] ACT_SEND    = 3'd0;
  localparam logic [2:0] ACT_RETX    = 3'd1;
  localparam logic [2:0] ACT_REFUSED = 3'd2;
  localparam logic [2:0] ACT_IGNORED = 3'd3;
  localparam logic [2:0] ACT_RELEASE = 3'd4;
  localparam logic [2:0] ACT_ENDED   = 3'd5;

  // register file
  localparam logic REG_WINDOW  = 1'b0;
  localparam logic REG_MAXPKT  = 1'b1;
  localparam logic [5:0]  WINDOW_RESET = 6'd63;
  localparam logic [15:0] MAXPKT_RESET = 16'd500;

  // parameter defaults
  localparam int SEQ_SPACE_DEF    = 256;
  localparam int WINDOW_LIMIT_DEF = 63;
  localparam int MAX_RETX_DEF     = 5;

  // field widths
  localparam int TIME_W = 40;
  localparam int TOT_W  = 56;
  localparam int SMP_W  = 16;
  localparam int DEN_W  = 26;
  localparam int TO_W   = 32;

  // timer constants
  localparam logic [8:0]       ACK_END      = 9'd256;
  localparam logic [TO_W-1:0]  TIMER_INIT   = 32'd100000;
  localparam logic [SMP_W-1:0] MIN_SAMPLES  = 16'd10;
  localparam logic [9:0]       US_PER_MS    = 10'd1000;
  localparam logic [10:0]      TIMER_STEP   = 11'd2000;
  // quotient at or above which 2000*(q+1) exceeds 32 bits
  localparam logic [TOT_W-1:0] TIMER_SAT_Q  = 56'd2147483;
  localparam logic [TO_W-1:0]  TIMER_MAX    = 32'hFFFF_FFFF;

endpackage

// File: rtl/gbn_div.sv
// ----------------------------------------------------------------------------
// gbn_div: restoring divider, one quotient bit per cycle
// Divides the RTT total by the sample count times 1000.
// ----------------------------------------------------------------------------
module gbn_div import gbn_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [TOT_W-1:0] dividend,
  input  logic [DEN_W-1:0] divisor,
  output logic             done,
  output logic [TOT_W-1:0] quotient
);

  localparam int CNT_W = $clog2(TOT_W + 1);

  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic [DEN_W-1:0] rem;
  logic [TOT_W-1:0] dvd;
  logic [DEN_W:0]   trial;

  assign trial    = {rem, dvd[TOT_W-1]};
  assign quotient = dvd;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && (cnt == CNT_W'(1));
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(TOT_W);
        rem  <= '0;
        dvd  <= dividend;
      end else if (busy) begin
        // trial subtract, shift the quotient bit in from the right
        if (trial >= {1'b0, divisor}) begin
          rem <= DEN_W'(trial - {1'b0, divisor});
          dvd <= {dvd[TOT_W-2:0], 1'b1};
        end else begin
          rem <= trial[DEN_W-1:0];
          dvd <= {dvd[TOT_W-2:0], 1'b0};
        end
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) busy <= 1'b0;
      end
    end
  end

endmodule

// File: rtl/go_back_n_sender_window.sv
// ----------------------------------------------------------------------------
// go_back_n_sender_window: Go-Back-N sender window control
// Sends, refuses, releases and retransmits packets, keeps RTT statistics
// and reports the timer value for each send.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake           | payload
//  ---------+-----------+---------------------+------------------------------
//  input    | in        | in_valid / in_stall | kind, ack_seq, now_us
//  result   | out       | out_valid/out_stall | action, seq, rtt_us,
//           |           |                     | timeout_us, attempt, last
//  config   | in        | APB write / read    | window limit, max_packets
//
//  One item at a time. A send or timer expiry first works out the timer
//  value, through the bit-serial divider once 10 RTT samples exist.
//  Each released or retransmitted packet takes a memory read, then an
//  update and its result. Reset clears the window and statistics; the
//  send-time and attempt memories need no clearing. A stalled result
//  holds the sequencer.
// ----------------------------------------------------------------------------
module go_back_n_sender_window import gbn_pkg::*; #(
  parameter int SEQ_SPACE    = SEQ_SPACE_DEF,
  parameter int WINDOW_LIMIT = WINDOW_LIMIT_DEF,
  parameter int MAX_RETX     = MAX_RETX_DEF
) (
  input  logic               clk,
  input  logic               rst,
  // input items
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         kind,
  input  logic [8:0]         ack_seq,
  input  logic [TIME_W-1:0]  now_us,
  // result items
  output logic               out_valid,
  input  logic               out_stall,
  output logic [2:0]         action,
  output logic [7:0]         seq,
  output logic [TIME_W-1:0]  rtt_us,
  output logic [TO_W-1:0]    timeout_us,
  output logic [2:0]         attempt,
  output logic               last,
  // configuration
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  localparam int SEQ_W   = $clog2(SEQ_SPACE);
  localparam int WIN_CAP = (WINDOW_LIMIT < SEQ_SPACE - 1) ? WINDOW_LIMIT : SEQ_SPACE - 1;
  localparam logic [SEQ_W-1:0] SEQ_TOP = SEQ_W'(SEQ_SPACE - 1);

  // sequencer states
  localparam logic [3:0] ST_IDLE   = 4'd0;
  localparam logic [3:0] ST_DECIDE = 4'd1;
  localparam logic [3:0] ST_TSTART = 4'd2;
  localparam logic [3:0] ST_TGO    = 4'd3;
  localparam logic [3:0] ST_TDIV   = 4'd4;
  localparam logic [3:0] ST_TMUL   = 4'd5;
  localparam logic [3:0] ST_SEND   = 4'd6;
  localparam logic [3:0] ST_R_RD   = 4'd7;
  localparam logic [3:0] ST_R_EM   = 4'd8;
  localparam logic [3:0] ST_R_END  = 4'd9;
  localparam logic [3:0] ST_X_RD   = 4'd10;
  localparam logic [3:0] ST_X_EM   = 4'd11;

  logic [3:0]        state;

  // configuration registers
  logic [5:0]        win_size;
  logic [15:0]       max_packets;

  // window state
  logic [SEQ_W-1:0]  base_seq;
  logic [SEQ_W-1:0]  next_seq;
  logic [5:0]        count;
  logic              stopped;
  logic [TOT_W-1:0]  rtt_total;
  logic [SMP_W-1:0]  rtt_samples;

  // latched item
  logic [1:0]        it_kind;
  logic [8:0]        it_ack;
  logic [TIME_W-1:0] it_now;

  // loop state
  logic [SEQ_W-1:0]  cur;
  logic [5:0]        idx;
  logic [TO_W-1:0]   timer_val;
  logic [DEN_W-1:0]  den;
  logic [TOT_W-1:0]  quo;

  // divider
  logic              div_start;
  logic              div_done;
  logic [TOT_W-1:0]  div_q;

  // memories
  logic [TIME_W-1:0] send_times [SEQ_SPACE];
  logic [2:0]        attempt_counts [SEQ_SPACE];
  logic [TIME_W-1:0] rd_time;
  logic [2:0]        rd_att;
  logic [SEQ_W-1:0]  mem_raddr;
  logic              mem_we;
  logic [SEQ_W-1:0]  mem_waddr;
  logic [2:0]        mem_watt;

  // datapath
  logic              out_free;
  logic [5:0]        win_eff;
  logic [SEQ_W:0]    ack_dist;
  logic              ack_in_range;
  logic [TIME_W-1:0] rtt_now;
  logic [TOT_W:0]    tot_sum;
  logic [TOT_W-1:0]  tot_next;
  logic [SMP_W-1:0]  smp_next;
  logic [2:0]        att_next;
  logic              cfg_wr;

  gbn_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (rtt_total),
    .divisor  (den),
    .done     (div_done),
    .quotient (div_q)
  );

  function automatic logic [SEQ_W-1:0] seq_inc(input logic [SEQ_W-1:0] s);
    return (s == SEQ_TOP) ? '0 : SEQ_W'(s + SEQ_W'(1));
  endfunction

  assign out_free  = !out_valid || !out_stall;
  assign in_stall  = (state != ST_IDLE);
  assign pready    = 1'b1;
  assign cfg_wr    = psel && penable && pwrite;
  assign prdata    = (paddr[2] == REG_MAXPKT) ? {16'd0, max_packets} : {26'd0, win_size};
  assign div_start = (state == ST_TGO);

  // effective window, capped by the window limit and the sequence space
  assign win_eff = (win_size > 6'(WIN_CAP)) ? 6'(WIN_CAP) : win_size;

  // distance of the ack from the window base, modulo the sequence space
  always_comb begin
    if (it_ack[SEQ_W-1:0] >= base_seq)
      ack_dist = (SEQ_W+1)'(it_ack[SEQ_W-1:0]) - (SEQ_W+1)'(base_seq);
    else
      ack_dist = (SEQ_W+1)'(it_ack[SEQ_W-1:0]) + (SEQ_W+1)'(SEQ_SPACE)
               - (SEQ_W+1)'(base_seq);
  end
  assign ack_in_range = (it_ack < 9'(SEQ_SPACE)) && (count != 6'd0)
                      && (ack_dist < (SEQ_W+1)'(count));

  // release arithmetic: round trip and saturating statistics
  assign rtt_now  = it_now - rd_time;
  assign tot_sum  = {1'b0, rtt_total} + (TOT_W+1)'(rtt_now);
  assign tot_next = tot_sum[TOT_W] ? {TOT_W{1'b1}} : tot_sum[TOT_W-1:0];
  assign smp_next = (rtt_samples == {SMP_W{1'b1}}) ? rtt_samples
                  : SMP_W'(rtt_samples + SMP_W'(1));
  assign att_next = 3'(rd_att + 3'd1);

  // memory ports: retransmit walks with cur, releases read at the base
  assign mem_raddr = (it_kind == KIND_TIMER) ? cur : base_seq;
  assign mem_we    = out_free && ((state == ST_SEND) ||
                     ((state == ST_X_EM) && (rd_att < 3'(MAX_RETX))));
  assign mem_waddr = (state == ST_SEND) ? next_seq : cur;
  assign mem_watt  = (state == ST_SEND) ? 3'd0 : att_next;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      send_times[mem_waddr]     <= it_now;
      attempt_counts[mem_waddr] <= mem_watt;
    end
  end

  always_ff @(posedge clk) begin
    rd_time <= send_times[mem_raddr];
    rd_att  <= attempt_counts[mem_raddr];
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      out_valid   <= 1'b0;
      win_size    <= WINDOW_RESET;
      max_packets <= MAXPKT_RESET;
      base_seq    <= '0;
      next_seq    <= '0;
      count       <= '0;
      stopped     <= 1'b0;
      rtt_total   <= '0;
      rtt_samples <= '0;
    end else begin
      // drop the result once taken; an emit below overrides
      if (out_valid && !out_stall) out_valid <= 1'b0;

      if (cfg_wr) begin
        if (paddr[2] == REG_WINDOW) win_size    <= pwdata[5:0];
        else                         max_packets <= pwdata[15:0];
      end

      case (state)
        ST_IDLE: begin
          if (in_valid) begin
            it_kind <= kind;
            it_ack  <= ack_seq;
            it_now  <= now_us;
            state   <= ST_DECIDE;
          end
        end

        ST_DECIDE: begin
          if (out_free) begin
            action     <= ACT_ENDED;
            seq        <= '0;
            rtt_us     <= '0;
            timeout_us <= '0;
            attempt    <= '0;
            last       <= 1'b1;
            state      <= ST_IDLE;
            if (it_kind == KIND_NONE) begin
              // unknown kind: no result
            end else if (stopped) begin
              out_valid <= 1'b1;
            end else if (it_kind == KIND_NEW) begin
              if (count < win_eff) begin
                state <= ST_TSTART;
              end else begin
                action    <= ACT_REFUSED;
                seq       <= 8'(next_seq);
                out_valid <= 1'b1;
              end
            end else if (it_kind == KIND_ACK) begin
              if (it_ack == ACK_END) begin
                stopped   <= 1'b1;
                out_valid <= 1'b1;
              end else if (!ack_in_range) begin
                action    <= ACT_IGNORED;
                seq       <= it_ack[7:0];
                out_valid <= 1'b1;
              end else begin
                state <= ST_R_RD;
              end
            end else if (count != 6'd0) begin
              state <= ST_TSTART;
            end
          end
        end

        // timer value: 100000 until 10 samples, else 2000*(avg/1000+1)
        ST_TSTART: begin
          cur <= base_seq;
          idx <= '0;
          if (rtt_samples < MIN_SAMPLES) begin
            timer_val <= TIMER_INIT;
            state     <= (it_kind == KIND_NEW) ? ST_SEND : ST_X_RD;
          end else begin
            den   <= DEN_W'(rtt_samples) * DEN_W'(US_PER_MS);
            state <= ST_TGO;
          end
        end

        ST_TGO: state <= ST_TDIV;

        ST_TDIV: begin
          if (div_done) begin
            quo   <= div_q;
            state <= ST_TMUL;
          end
        end

        ST_TMUL: begin
          if (quo >= TIMER_SAT_Q)
            timer_val <= TIMER_MAX;
          else
            timer_val <= (TO_W'(quo[21:0]) + TO_W'(1)) * TO_W'(TIMER_STEP);
          state <= (it_kind == KIND_NEW) ? ST_SEND : ST_X_RD;
        end

        ST_SEND: begin
          if (out_free) begin
            action     <= ACT_SEND;
            seq        <= 8'(next_seq);
            rtt_us     <= '0;
            timeout_us <= timer_val;
            attempt    <= '0;
            last       <= 1'b1;
            out_valid  <= 1'b1;
            next_seq   <= seq_inc(next_seq);
            count      <= count + 6'd1;
            state      <= ST_IDLE;
          end
        end

        ST_R_RD: state <= ST_R_EM;

        ST_R_EM: begin
          if (out_free) begin
            action      <= ACT_RELEASE;
            seq         <= 8'(base_seq);
            rtt_us      <= rtt_now;
            timeout_us  <= '0;
            attempt     <= rd_att;
            out_valid   <= 1'b1;
            rtt_total   <= tot_next;
            rtt_samples <= smp_next;
            base_seq    <= seq_inc(base_seq);
            count       <= count - 6'd1;
            cur         <= base_seq;
            if (smp_next >= max_packets) begin
              stopped <= 1'b1;
              last    <= 1'b0;
              state   <= ST_R_END;
            end else if ((base_seq == it_ack[SEQ_W-1:0]) || (count == 6'd1)) begin
              last  <= 1'b1;
              state <= ST_IDLE;
            end else begin
              last  <= 1'b0;
              state <= ST_R_RD;
            end
          end
        end

        ST_R_END: begin
          if (out_free) begin
            action     <= ACT_ENDED;
            seq        <= 8'(cur);
            rtt_us     <= '0;
            timeout_us <= '0;
            attempt    <= '0;
            last       <= 1'b1;
            out_valid  <= 1'b1;
            state      <= ST_IDLE;
          end
        end

        ST_X_RD: state <= ST_X_EM;

        ST_X_EM: begin
          if (out_free) begin
            seq       <= 8'(cur);
            rtt_us    <= '0;
            out_valid <= 1'b1;
            if (rd_att >= 3'(MAX_RETX)) begin
              // retransmit limit reached: end the connection here
              stopped    <= 1'b1;
              action     <= ACT_ENDED;
              timeout_us <= '0;
              attempt    <= '0;
              last       <= 1'b1;
              state      <= ST_IDLE;
            end else begin
              action     <= ACT_RETX;
              timeout_us <= timer_val;
              attempt    <= att_next;
              cur        <= seq_inc(cur);
              idx        <= idx + 6'd1;
              if (idx + 6'd1 == count) begin
                last  <= 1'b1;
                state <= ST_IDLE;
              end else begin
                last  <= 1'b0;
                state <= ST_X_RD;
              end
            end
          end
        end

        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

// File: rtl/gbn_checker.sv
// ----------------------------------------------------------------------------
// gbn_checker: port-level checks for the Go-Back-N sender window
// Watches the item and result channels of the top level.
// ----------------------------------------------------------------------------
module gbn_checker import gbn_pkg::*; (
  input logic              clk,
  input logic              rst,
  input logic              in_valid,
  input logic              in_stall,
  input logic              out_valid,
  input logic              out_stall,
  input logic [2:0]        action,
  input logic [TIME_W-1:0] rtt_us,
  input logic [TO_W-1:0]   timeout_us,
  input logic              last
);

  // an accepted item closes the input in the next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input open right after an accepted item");

  // a stalled result holds
  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(action) && $stable(last))
    else $error("stalled result changed");

  // only a release carries a round trip
  a_rtt_release_only: assert property (@(posedge clk) disable iff (rst)
    out_valid && (action != ACT_RELEASE) |-> (rtt_us == '0))
    else $error("round trip on a result that is not a release");

  // a new send is always the sole result of its item
  a_send_is_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && (action == ACT_SEND) |-> last)
    else $error("send result not marked last");

  // timer value only on sends and retransmits
  a_timeout_sends_only: assert property (@(posedge clk) disable iff (rst)
    out_valid && (action != ACT_SEND) && (action != ACT_RETX) |-> (timeout_us == '0))
    else $error("timer value on a result that is not a send");

endmodule

bind go_back_n_sender_window gbn_checker u_gbn_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (in_valid),
  .in_stall   (in_stall),
  .out_valid  (out_valid),
  .out_stall  (out_stall),
  .action     (action),
  .rtt_us     (rtt_us),
  .timeout_us (timeout_us),
  .last       (last)
);

// File: tb/go_back_n_sender_window_test.sv
// ----------------------------------------------------------------------------
// go_back_n_sender_window_test: self-checking bench for the Go-Back-N window
// Drives offers, acks and timer expiries with random gaps and result stalls.
// It predicts every result from its own copy of the window and the RTT
// statistics, and checks each result in order. Runs through several window
// and packet-limit settings, then closes the connection one of four ways.
// ----------------------------------------------------------------------------
module go_back_n_sender_window_test;
  import gbn_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int SETTLE_CYCLES  = 200;

  typedef struct packed {
    logic [2:0]        action;
    logic [7:0]        seq;
    logic [TIME_W-1:0] rtt;
    logic [TO_W-1:0]   tmo;
    logic [2:0]        att;
    logic              last;
  } gbn_result_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [1:0]        kind = KIND_NONE;
  logic [8:0]        ack_seq = '0;
  logic [TIME_W-1:0] now_us = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [2:0]        action;
  logic [7:0]        seq;
  logic [TIME_W-1:0] rtt_us;
  logic [TO_W-1:0]   timeout_us;
  logic [2:0]        attempt;
  logic              last;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [2:0]        paddr = '0;
  logic [31:0]       pwdata = '0;
  logic [31:0]       prdata;
  logic              pready;

  go_back_n_sender_window dut (.*);

  always #1 clk = ~clk;

  // shadow copy of the block: configuration and window state
  logic [5:0]        win_cfg = WINDOW_RESET;
  logic [15:0]       maxpkt_cfg = MAXPKT_RESET;
  logic [7:0]        win_base = '0;
  logic [7:0]        win_next = '0;
  int unsigned       in_flight = 0;
  logic [TIME_W-1:0] sent_at [256];
  logic [2:0]        retx_cnt [256];
  logic [TOT_W-1:0]  rtt_sum = '0;
  logic [SMP_W-1:0]  rtt_cnt = '0;
  bit                conn_closed = 1'b0;

  gbn_result_t       pending_results [$];
  logic [TIME_W-1:0] clock_us = '0;

  int  n_errors = 0;
  int  n_items = 0;
  int  n_results = 0;
  int  n_retx = 0;
  int  n_release = 0;
  int  idle_pct = 16;
  int  quiet_cycles = 0;
  int  stall_free = 0;
  int  end_cause;

  // Timer to arm: fixed until ten samples, then 2000 us times one more than the mean in whole ms.
  function automatic logic [TO_W-1:0] arm_value();
    logic [63:0] v;
    if (rtt_cnt < MIN_SAMPLES) return TIMER_INIT;
    v = 64'(2000) * ((64'(rtt_sum) / 64'(rtt_cnt)) / 64'(1000) + 64'(1));
    if (v > 64'hFFFF_FFFF) v = 64'hFFFF_FFFF;
    return v[TO_W-1:0];
  endfunction

  function automatic void push_result(logic [2:0] act, logic [7:0] s,
                                      logic [TIME_W-1:0] r, logic [TO_W-1:0] t,
                                      logic [2:0] a);
    gbn_result_t e;
    e = '{action: act, seq: s, rtt: r, tmo: t, att: a, last: 1'b0};
    pending_results.push_back(e);
  endfunction

  // Advance the shadow window by one accepted item and queue its results.
  function automatic void predict_window(logic [1:0] k, logic [8:0] a,
                                         logic [TIME_W-1:0] t);
    int unsigned       before_n;
    int unsigned       w;
    int unsigned       i;
    logic [7:0]        s;
    logic [TIME_W-1:0] r;
    logic [TOT_W:0]    sum;
    logic [TO_W-1:0]   to;
    before_n = pending_results.size();
    if (k == KIND_NONE) return;
    if (conn_closed) begin
      push_result(ACT_ENDED, 8'd0, '0, '0, 3'd0);
    end else if (k == KIND_NEW) begin
      w = win_cfg;
      if (w > 63) w = 63;
      if (in_flight < w) begin
        sent_at[win_next] = t;
        retx_cnt[win_next] = 3'd0;
        push_result(ACT_SEND, win_next, '0, arm_value(), 3'd0);
        win_next++;
        in_flight++;
      end else begin
        push_result(ACT_REFUSED, win_next, '0, '0, 3'd0);
      end
    end else if (k == KIND_ACK) begin
      if (a == ACK_END) begin
        conn_closed = 1'b1;
        push_result(ACT_ENDED, 8'd0, '0, '0, 3'd0);
      end else if (a[8] || in_flight == 0 || 32'(8'(a[7:0] - win_base)) >= in_flight) begin
        push_result(ACT_IGNORED, a[7:0], '0, '0, 3'd0);
      end else begin
        forever begin
          s = win_base;
          r = t - sent_at[s];
          sum = {1'b0, rtt_sum} + (TOT_W+1)'(r);
          rtt_sum = sum[TOT_W] ? '1 : sum[TOT_W-1:0];
          if (rtt_cnt != '1) rtt_cnt++;
          push_result(ACT_RELEASE, s, r, '0, retx_cnt[s]);
          win_base++;
          in_flight--;
          if (rtt_cnt >= maxpkt_cfg) begin
            conn_closed = 1'b1;
            push_result(ACT_ENDED, s, '0, '0, 3'd0);
            break;
          end
          if (s == a[7:0] || in_flight == 0) break;
        end
      end
    end else begin
      to = arm_value();
      s = win_base;
      for (i = 0; i < in_flight; i++) begin
        if (retx_cnt[s] >= 3'(MAX_RETX_DEF)) begin
          conn_closed = 1'b1;
          push_result(ACT_ENDED, s, '0, '0, 3'd0);
          break;
        end
        sent_at[s] = t;
        retx_cnt[s] = retx_cnt[s] + 3'd1;
        push_result(ACT_RETX, s, '0, to, retx_cnt[s]);
        s++;
      end
    end
    if (pending_results.size() > before_n)
      pending_results[pending_results.size()-1].last = 1'b1;
  endfunction

  // Offer one item; valid stays high into the next item unless a gap is drawn.
  task automatic send_item(logic [1:0] k, logic [8:0] a, logic [TIME_W-1:0] t);
    if (quiet_cycles == 0 && $urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < 40);
    end
    in_valid <= 1'b1;
    kind     <= k;
    ack_seq  <= a;
    now_us   <= t;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_window(k, a, t);
    n_items++;
    if (quiet_cycles > 0) quiet_cycles--;
  endtask

  // Drop valid and hold until every result is in and the block has settled.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] addr, logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (addr == 3'(4 * REG_WINDOW)) win_cfg = value[5:0];
    else maxpkt_cfg = value[15:0];
  endtask

  task automatic set_config(logic [5:0] w, logic [15:0] m);
    drain();
    write_reg(3'(4 * REG_WINDOW), 32'(w));
    write_reg(3'(4 * REG_MAXPKT), 32'(m));
    @(posedge clk);
  endtask

  function automatic logic [TIME_W-1:0] tick_clock();
    if ($urandom_range(99) < 3) clock_us = TIME_W'({$urandom, $urandom});
    else clock_us = clock_us + TIME_W'($urandom_range(1, 5000));
    return clock_us;
  endfunction

  // One random item, biased towards well-formed traffic. Hold off timers
  // that would hit the retransmit limit so the connection stays open.
  task automatic random_item();
    int unsigned r;
    logic [8:0]  a;
    r = $urandom_range(99);
    if (r < 40 || (r < 85 && in_flight == 0)) begin
      send_item(KIND_NEW, 9'($urandom), tick_clock());
    end else if (r < 75 || retx_cnt[win_base] >= 3'd4) begin
      a = {1'b0, win_base + 8'($urandom_range(in_flight - 1))};
      send_item(KIND_ACK, a, tick_clock());
    end else if (r < 85) begin
      send_item(KIND_TIMER, 9'($urandom), tick_clock());
    end else if (r < 93) begin
      a = 9'($urandom);
      if (a == ACK_END) a = 9'd511;
      send_item(KIND_ACK, a, tick_clock());
    end else begin
      send_item(KIND_NONE, 9'($urandom), TIME_W'({$urandom, $urandom}));
    end
  endtask

  // Check each result against the oldest expectation.
  task automatic report(string name, logic [63:0] exp_v, logic [63:0] got_v);
    $display("%0t: mismatch in %s: expected %0h, got %0h", $time, name, exp_v, got_v);
    n_errors++;
  endtask

  always @(posedge clk) begin
    gbn_result_t e;
    if (!rst && out_valid && !out_stall) begin
      n_results++;
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result: expected none, got action %0d seq %0d",
                 $time, action, seq);
        n_errors++;
      end else begin
        e = pending_results.pop_front();
        if (e.action !== action)   report("action", e.action, action);
        if (e.seq !== seq)         report("seq", e.seq, seq);
        if (e.rtt !== rtt_us)      report("rtt_us", e.rtt, rtt_us);
        if (e.tmo !== timeout_us)  report("timeout_us", e.tmo, timeout_us);
        if (e.att !== attempt)     report("attempt", e.att, attempt);
        if (e.last !== last)       report("last", e.last, last);
        if (e.action == ACT_RETX) n_retx++;
        if (e.action == ACT_RELEASE) n_release++;
      end
    end
  end

  // Stall results at random, except during a stall-free stretch.
  always @(posedge clk) begin
    if (stall_free > 0) begin
      out_stall <= 1'b0;
      stall_free <= stall_free - 1;
    end else begin
      out_stall <= ($urandom_range(99) < idle_pct);
    end
  end

  // End the run if nothing moves on either channel for too long.
  int idle_count = 0;
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_count <= 0;
    else idle_count <= idle_count + 1;
    if (idle_count >= WATCHDOG_LIMIT) begin
      $display("watchdog expired with %0d results outstanding", pending_results.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Empty window cases, extreme times, wrap of the RTT, ranges of ack.
  task automatic test_directed_basics();
    send_item(KIND_TIMER, 9'd0, 40'd5);
    send_item(KIND_ACK, 9'd0, 40'd6);
    send_item(KIND_ACK, 9'd511, 40'd7);
    send_item(KIND_NEW, 9'd0, 40'd0);
    send_item(KIND_NEW, 9'd0, '1);
    send_item(KIND_NEW, 9'd0, 40'hFF_FFFF_FF00);
    send_item(KIND_NEW, 9'd0, 40'hAA_AAAA_AAAA);
    send_item(KIND_ACK, 9'd4, 40'd100);
    send_item(KIND_ACK, 9'd255, 40'd100);
    send_item(KIND_ACK, 9'd300, 40'd100);
    send_item(KIND_NONE, 9'h1FF, '1);
    send_item(KIND_ACK, 9'd1, 40'd50);
    send_item(KIND_TIMER, 9'd0, 40'h55_5555_5555);
    send_item(KIND_TIMER, 9'd0, 40'h55_5555_6000);
    send_item(KIND_ACK, 9'd3, 40'h55_5555_7000);
    clock_us = 40'h55_5555_8000;
  endtask

  // Smallest windows: one packet in flight, then every offer refused.
  task automatic test_window_extremes();
    set_config(6'd1, 16'd65535);
    send_item(KIND_NEW, 9'd0, tick_clock());
    send_item(KIND_NEW, 9'd0, tick_clock());
    send_item(KIND_ACK, {1'b0, win_next}, tick_clock());
    send_item(KIND_NEW, 9'd0, tick_clock());
    set_config(6'd0, 16'd65535);
    send_item(KIND_NEW, 9'd0, tick_clock());
    send_item(KIND_ACK, {1'b0, win_base}, tick_clock());
    send_item(KIND_NEW, 9'd0, tick_clock());
  endtask

  // Random traffic in phases with different settings.
  task automatic test_random_traffic();
    set_config(6'd63, 16'd65535);
    repeat (60) random_item();
    set_config(6'd1, 16'($urandom_range(400, 65535)));
    repeat (30) random_item();
    set_config(6'($urandom_range(2, 62)), 16'($urandom_range(400, 65535)));
    quiet_cycles = 40;
    stall_free = 400;
    repeat (50) random_item();
    set_config(6'd63, MAXPKT_RESET);
    repeat (40) random_item();
  endtask

  // Sender holds off until the block has delivered everything, then resumes.
  task automatic test_pause();
    repeat (3) send_item(KIND_NEW, 9'd0, tick_clock());
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    send_item(KIND_TIMER, 9'd0, tick_clock());
    send_item(KIND_ACK, {1'b0, win_next - 8'd1}, tick_clock());
  endtask

  // Close the connection one of four ways, then offer items while closed.
  task automatic test_connection_end();
    end_cause = $urandom_range(3);
    case (end_cause)
      0: begin
        send_item(KIND_NEW, 9'd0, tick_clock());
        send_item(KIND_ACK, ACK_END, tick_clock());
      end
      1, 2: begin
        set_config(6'd63, (end_cause == 1) ? 16'd0 : 16'd1);
        send_item(KIND_NEW, 9'd0, tick_clock());
        send_item(KIND_NEW, 9'd0, tick_clock());
        send_item(KIND_ACK, {1'b0, win_next - 8'd1}, tick_clock());
      end
      default: begin
        send_item(KIND_NEW, 9'd0, tick_clock());
        repeat (7) send_item(KIND_TIMER, 9'd0, tick_clock());
      end
    endcase
    send_item(KIND_NEW, 9'd0, tick_clock());
    send_item(KIND_ACK, 9'd1, tick_clock());
    send_item(KIND_TIMER, 9'd0, tick_clock());
    send_item(KIND_NONE, 9'd0, tick_clock());
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed_basics();
    test_window_extremes();
    test_random_traffic();
    test_pause();
    test_connection_end();
    drain();
    $display("covered %0d items and %0d results (%0d releases, %0d retransmits)",
             n_items, n_results, n_release, n_retx);
    $display("window settings 0, 1, mid and 63; connection closed by cause %0d",
             end_cause);
    if (n_errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("%0d mismatches", n_errors);
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
